// ===== hw/rtl/psds_pkg.sv =====
// Shared constants, widths and types for the point to segment squared-distance block.
// No dependencies; used by the divider, the top level and the checker.
package psds_pkg;

    // fraction bits of the projection parameter t
    localparam int TFB       = 16;
    // coordinate width and derived datapath widths
    localparam int C_W       = 16;
    localparam int D_W       = C_W + 1;          // differences k and d
    localparam int P_W       = 2 * D_W;          // k.d and d.d products
    localparam int N_W       = P_W + 1;          // numerator sum
    localparam int DEN_W     = 2 * D_W - 1;      // |d|^2, unsigned
    localparam int TW        = TFB + 1;          // clamped t, 0 .. 1.0
    localparam int FX_W      = TFB + D_W + 2;    // offset k + t*d, signed
    localparam int LO_W      = (FX_W + 1) / 2;   // low half for squaring
    localparam int HI_W      = FX_W - LO_W;
    localparam int SQ_W      = 2 * FX_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int SH        = 2 * TFB - 8;      // keep 8 fraction bits
    localparam int DS_W      = 41;
    localparam int S_TDATA_W = 6 * C_W;
    localparam int M_TDATA_W = ((DS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - DS_W;

    typedef logic signed [D_W-1:0]   diff_t;
    typedef logic signed [P_W-1:0]   prod_t;
    typedef logic signed [N_W-1:0]   num_t;
    typedef logic        [DEN_W-1:0] den_t;
    typedef logic        [TW-1:0]    t_t;
    typedef logic signed [FX_W-1:0]  fx_t;
    typedef logic        [FX_W-1:0]  ax_t;
    typedef logic        [SQ_W-1:0]  sq_t;
    typedef logic        [SUM_W-1:0] sum_t;

    // how t is settled for one item
    typedef enum logic [1:0] {
        T_ZERO = 2'b00,
        T_ONE  = 2'b01,
        T_DIV  = 2'b10
    } tsel_t;

    localparam t_t T_ONE_VAL = t_t'(1) << TFB;

    // payload that rides alongside the divider
    typedef struct packed {
        diff_t kx;
        diff_t ky;
        diff_t dx;
        diff_t dy;
        tsel_t sel;
        logic  seg_pt;
    } side_t;

endpackage

// ===== hw/rtl/psds_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, TFB stages.
// Depends on psds_pkg; carries a side_t payload in step with the quotient.
module psds_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [psds_pkg::DEN_W-1:0] in_num,
    input  logic [psds_pkg::DEN_W-1:0] in_den,
    input  psds_pkg::side_t           in_side,
    output logic                      out_valid,
    output logic [psds_pkg::TFB-1:0]  out_q,
    output psds_pkg::side_t           out_side
);

    localparam int NS = psds_pkg::TFB;
    localparam int DW = psds_pkg::DEN_W;

    logic              v_reg    [NS];
    logic [DW-1:0]     rem_reg  [NS];
    logic [DW-1:0]     den_reg  [NS];
    logic [NS-1:0]     q_reg    [NS];
    psds_pkg::side_t   side_reg [NS];

    logic              v_next    [NS];
    logic [DW-1:0]     rem_next  [NS];
    logic [DW-1:0]     den_next  [NS];
    logic [NS-1:0]     q_next    [NS];
    psds_pkg::side_t   side_next [NS];

    // one trial subtract per stage, stages independent of each other
    always_comb begin
        logic [DW-1:0]   rem_prev;
        logic [DW-1:0]   den_prev;
        logic [NS-1:0]   q_prev;
        logic [DW:0]     shifted;
        logic [DW:0]     trial;
        logic            take;
        for (int i = 0; i < NS; i++) begin
            if (i == 0) begin
                v_next[i]    = in_valid;
                rem_prev     = in_num;
                den_prev     = in_den;
                q_prev       = '0;
                side_next[i] = in_side;
            end else begin
                v_next[i]    = v_reg[i-1];
                rem_prev     = rem_reg[i-1];
                den_prev     = den_reg[i-1];
                q_prev       = q_reg[i-1];
                side_next[i] = side_reg[i-1];
            end
            shifted     = {rem_prev, 1'b0};
            trial       = shifted - {1'b0, den_prev};
            take        = (shifted >= {1'b0, den_prev});
            rem_next[i] = take ? trial[DW-1:0] : shifted[DW-1:0];
            den_next[i] = den_prev;
            q_next[i]   = {q_prev[NS-2:0], take};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < NS; i++) v_reg[i] <= v_next[i];
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                rem_reg[i]  <= rem_next[i];
                den_reg[i]  <= den_next[i];
                q_reg[i]    <= q_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ===== hw/rtl/point_segment_distance_squared.sv =====
// Squared distance from a query point to a 2D segment, fixed point, pipelined.
// Pipeline: 4 setup stages, 16 divider stages and 7 offset and squaring stages; a beat
// taken while the pipeline is stalled waits in the input skid register first.
// Throughput: one beat per cycle; the whole pipeline stalls only while m_tready is low.
// Reset: aresetn synchronous, active low; clears all valid bits and the skid full flag.
// Depends on psds_pkg and psds_divider.
module point_segment_distance_squared (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // line_start_x, line_start_y, line_end_x, line_end_y, point_x, point_y
    input  logic [psds_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // distance_squared, zero padding
    output logic [psds_pkg::M_TDATA_W-1:0]  m_tdata,
    // segment_is_point
    output logic                            m_tuser
);

    localparam int CW = psds_pkg::C_W;

    logic en;
    logic s_acc;

    // input skid register
    logic                           skid_full_reg;
    logic [psds_pkg::S_TDATA_W-1:0] skid_data_reg;
    logic                           in_v;
    logic [psds_pkg::S_TDATA_W-1:0] in_data;

    // stage 1: differences
    logic            v1_reg;
    psds_pkg::diff_t kx1_reg, ky1_reg, dx1_reg, dy1_reg;
    // stage 2: products
    logic            v2_reg;
    psds_pkg::diff_t kx2_reg, ky2_reg, dx2_reg, dy2_reg;
    psds_pkg::prod_t pkx2_reg, pky2_reg, pdx2_reg, pdy2_reg;
    // stage 3: numerator and denominator
    logic            v3_reg;
    psds_pkg::diff_t kx3_reg, ky3_reg, dx3_reg, dy3_reg;
    psds_pkg::num_t  num3_reg;
    psds_pkg::den_t  den3_reg;
    psds_pkg::num_t  num3_next;
    psds_pkg::num_t  dd3_sum;
    // stage 4: clamp decision
    logic            v4_reg;
    psds_pkg::den_t  num4_reg, den4_reg;
    psds_pkg::side_t side4_reg;
    psds_pkg::side_t side4_next;
    psds_pkg::den_t  num4_next;
    // divider output
    logic                    div_v;
    logic [psds_pkg::TFB-1:0] div_q;
    psds_pkg::side_t         div_side;
    // stage A: clamped t
    logic            va_reg;
    psds_pkg::t_t    ta_reg;
    psds_pkg::t_t    ta_next;
    psds_pkg::diff_t kxa_reg, kya_reg, dxa_reg, dya_reg;
    logic            sega_reg;
    // stage B: t*d
    logic            vb_reg;
    psds_pkg::fx_t   prxb_reg, pryb_reg;
    psds_pkg::diff_t kxb_reg, kyb_reg;
    logic            segb_reg;
    // stage C: offset
    logic            vc_reg;
    psds_pkg::fx_t   fxc_reg, fyc_reg;
    logic            segc_reg;
    // stage D: magnitude
    logic            vd_reg;
    psds_pkg::ax_t   axd_reg, ayd_reg;
    logic            segd_reg;
    // stage E: partial squares
    logic                                      ve_reg;
    logic [2*psds_pkg::HI_W-1:0]               hhx_reg, hhy_reg;
    logic [psds_pkg::HI_W+psds_pkg::LO_W-1:0]  hlx_reg, hly_reg;
    logic [2*psds_pkg::LO_W-1:0]               llx_reg, lly_reg;
    logic                                      sege_reg;
    // stage F: squares
    logic            vf_reg;
    psds_pkg::sq_t   sqx_reg, sqy_reg;
    logic            segf_reg;
    // output register
    logic                      m_tvalid_reg;
    logic [psds_pkg::DS_W-1:0] ds_reg;
    logic                      seg_out_reg;
    psds_pkg::sum_t            total;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = !skid_full_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign in_v     = skid_full_reg || s_tvalid;
    assign in_data  = skid_full_reg ? skid_data_reg : s_tdata;

    // skid register takes a beat that arrives while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg && en) begin
            skid_full_reg <= 1'b0;
        end else if (s_acc && !en) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !en) begin
            skid_data_reg <= s_tdata;
        end
    end

    // combinational parts of the setup stages
    always_comb begin
        dd3_sum   = psds_pkg::num_t'(pdx2_reg) + psds_pkg::num_t'(pdy2_reg);
        num3_next = -(psds_pkg::num_t'(pkx2_reg) + psds_pkg::num_t'(pky2_reg));

        side4_next.kx     = kx3_reg;
        side4_next.ky     = ky3_reg;
        side4_next.dx     = dx3_reg;
        side4_next.dy     = dy3_reg;
        side4_next.seg_pt = (den3_reg == '0);
        // t = 0 before the start (and for a zero-length segment), 1 past the end
        if (num3_reg[psds_pkg::N_W-1] || (num3_reg == '0)) begin
            side4_next.sel = psds_pkg::T_ZERO;
        end else if (num3_reg >= $signed({{(psds_pkg::N_W-psds_pkg::DEN_W){1'b0}},
                                          den3_reg})) begin
            side4_next.sel = psds_pkg::T_ONE;
        end else begin
            side4_next.sel = psds_pkg::T_DIV;
        end
        num4_next = (side4_next.sel == psds_pkg::T_DIV) ?
                    num3_reg[psds_pkg::DEN_W-1:0] : '0;
    end

    // valid bits of the local stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            vd_reg       <= 1'b0;
            ve_reg       <= 1'b0;
            vf_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= in_v;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            va_reg       <= div_v;
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            vd_reg       <= vc_reg;
            ve_reg       <= vd_reg;
            vf_reg       <= ve_reg;
            m_tvalid_reg <= vf_reg;
        end
    end

    // setup stages: k = start - point, d = end - start, dot products
    always_ff @(posedge aclk) begin
        if (en) begin
            kx1_reg <= psds_pkg::diff_t'($signed(in_data[0*CW +: CW]))
                     - psds_pkg::diff_t'($signed(in_data[4*CW +: CW]));
            ky1_reg <= psds_pkg::diff_t'($signed(in_data[1*CW +: CW]))
                     - psds_pkg::diff_t'($signed(in_data[5*CW +: CW]));
            dx1_reg <= psds_pkg::diff_t'($signed(in_data[2*CW +: CW]))
                     - psds_pkg::diff_t'($signed(in_data[0*CW +: CW]));
            dy1_reg <= psds_pkg::diff_t'($signed(in_data[3*CW +: CW]))
                     - psds_pkg::diff_t'($signed(in_data[1*CW +: CW]));

            kx2_reg  <= kx1_reg;
            ky2_reg  <= ky1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            pkx2_reg <= kx1_reg * dx1_reg;
            pky2_reg <= ky1_reg * dy1_reg;
            pdx2_reg <= dx1_reg * dx1_reg;
            pdy2_reg <= dy1_reg * dy1_reg;

            kx3_reg  <= kx2_reg;
            ky3_reg  <= ky2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            num3_reg <= num3_next;
            den3_reg <= dd3_sum[psds_pkg::DEN_W-1:0];

            num4_reg  <= num4_next;
            den4_reg  <= den3_reg;
            side4_reg <= side4_next;
        end
    end

    // t = num * 2^TFB / den, one bit per stage
    psds_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (div_v),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    // pick the clamped t
    always_comb begin
        case (div_side.sel)
            psds_pkg::T_ZERO: ta_next = '0;
            psds_pkg::T_ONE:  ta_next = psds_pkg::T_ONE_VAL;
            psds_pkg::T_DIV:  ta_next = {1'b0, div_q};
            default:          ta_next = '0;
        endcase
    end

    // offset k + t*d, its magnitude and square
    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg   <= ta_next;
            kxa_reg  <= div_side.kx;
            kya_reg  <= div_side.ky;
            dxa_reg  <= div_side.dx;
            dya_reg  <= div_side.dy;
            sega_reg <= div_side.seg_pt;

            prxb_reg <= psds_pkg::fx_t'($signed({1'b0, ta_reg})) * psds_pkg::fx_t'(dxa_reg);
            pryb_reg <= psds_pkg::fx_t'($signed({1'b0, ta_reg})) * psds_pkg::fx_t'(dya_reg);
            kxb_reg  <= kxa_reg;
            kyb_reg  <= kya_reg;
            segb_reg <= sega_reg;

            fxc_reg  <= (psds_pkg::fx_t'(kxb_reg) <<< psds_pkg::TFB) + prxb_reg;
            fyc_reg  <= (psds_pkg::fx_t'(kyb_reg) <<< psds_pkg::TFB) + pryb_reg;
            segc_reg <= segb_reg;

            axd_reg  <= fxc_reg[psds_pkg::FX_W-1] ? psds_pkg::ax_t'(-fxc_reg)
                                                   : psds_pkg::ax_t'(fxc_reg);
            ayd_reg  <= fyc_reg[psds_pkg::FX_W-1] ? psds_pkg::ax_t'(-fyc_reg)
                                                   : psds_pkg::ax_t'(fyc_reg);
            segd_reg <= segc_reg;

            // split each magnitude in halves so every multiply stays narrow
            hhx_reg  <= axd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W]
                      * axd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W];
            hlx_reg  <= axd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W]
                      * axd_reg[psds_pkg::LO_W-1:0];
            llx_reg  <= axd_reg[psds_pkg::LO_W-1:0] * axd_reg[psds_pkg::LO_W-1:0];
            hhy_reg  <= ayd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W]
                      * ayd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W];
            hly_reg  <= ayd_reg[psds_pkg::FX_W-1:psds_pkg::LO_W]
                      * ayd_reg[psds_pkg::LO_W-1:0];
            lly_reg  <= ayd_reg[psds_pkg::LO_W-1:0] * ayd_reg[psds_pkg::LO_W-1:0];
            sege_reg <= segd_reg;

            sqx_reg  <= (psds_pkg::sq_t'(hhx_reg) << (2 * psds_pkg::LO_W))
                      + (psds_pkg::sq_t'(hlx_reg) << (psds_pkg::LO_W + 1))
                      + psds_pkg::sq_t'(llx_reg);
            sqy_reg  <= (psds_pkg::sq_t'(hhy_reg) << (2 * psds_pkg::LO_W))
                      + (psds_pkg::sq_t'(hly_reg) << (psds_pkg::LO_W + 1))
                      + psds_pkg::sq_t'(lly_reg);
            segf_reg <= sege_reg;

            ds_reg      <= total[psds_pkg::SH +: psds_pkg::DS_W];
            seg_out_reg <= segf_reg;
        end
    end

    // sum of squares, truncated to 8 fraction bits on the way out
    assign total = psds_pkg::sum_t'(sqx_reg) + psds_pkg::sum_t'(sqy_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{psds_pkg::M_PAD_W{1'b0}}, ds_reg};
    assign m_tuser  = seg_out_reg;

endmodule

// ===== hw/rtl/psds_checker.sv =====
// Port-level checks for point_segment_distance_squared, bound to the top level.
// Depends on psds_pkg for port widths.
module psds_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [psds_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // input side only backs off when the output was stalled
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready dropped without an output stall");

    // a held input beat drains as soon as the output moves
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("s_tready stuck low with output ready");

endmodule

bind point_segment_distance_squared psds_checker u_psds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
